>>> rtl/fdl_pkg.sv
// Shared types and constants for the fractional delay / lowpass / gain block.
// Holds payload structs, configuration layout, register indexes and the
// datapath operation codes used between controller and datapath.
package fdl_pkg;

  localparam int DELAY_DEPTH_DEF = 2048;
  localparam int CHANNELS_DEF    = 2;

  localparam int SAMPLE_BITS = 24;
  localparam int SCALE_BITS  = 8;
  localparam int LP_W        = SAMPLE_BITS + SCALE_BITS;
  localparam int COEF_W      = 16;
  localparam int CFG_IDX_W   = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_BYPASS    = 3'd0;
  localparam cfg_idx_t CFG_DELAY     = 3'd1;
  localparam cfg_idx_t CFG_LP_COEFF  = 3'd2;
  localparam cfg_idx_t CFG_DIST_GAIN = 3'd3;
  localparam cfg_idx_t CFG_OUT_GAIN  = 3'd4;

  localparam logic [COEF_W-1:0] DELAY_RST     = 16'd0;
  localparam logic [COEF_W-1:0] LP_COEFF_RST  = 16'd32768;
  localparam logic [COEF_W-1:0] DIST_GAIN_RST = 16'd32768;
  localparam logic [COEF_W-1:0] OUT_GAIN_RST  = 16'd4096;

  typedef struct packed {
    logic              bypass;
    logic [COEF_W-1:0] delay_amount;
    logic [COEF_W-1:0] lowpass_coeff;
    logic [COEF_W-1:0] distance_gain;
    logic [COEF_W-1:0] output_gain;
  } cfg_t;

  typedef struct packed {
    logic                          channel;
    logic signed [SAMPLE_BITS-1:0] sample_in;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          clipped;
  } out_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_WRITE,
    OP_READ1,
    OP_READ2,
    OP_DIFF,
    OP_MUL_INTERP,
    OP_ERR,
    OP_MUL_LP,
    OP_LP_UPD,
    OP_MUL_DIST,
    OP_ROUND_T,
    OP_MUL_OUT,
    OP_FINISH,
    OP_BYPASS
  } op_t;

endpackage

>>> rtl/fdl_datapath.sv
// Datapath: per-channel delay memory, write positions, lowpass state, one shared
// multiplier with rounding and saturation, and the output payload register.
// Depends on fdl_pkg; driven one operation per cycle by fdl_ctrl.
module fdl_datapath #(
  parameter int DELAY_DEPTH = fdl_pkg::DELAY_DEPTH_DEF,
  parameter int CHANNELS    = fdl_pkg::CHANNELS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  fdl_pkg::op_t  op,
  input  fdl_pkg::cfg_t cfg,
  input  fdl_pkg::in_t  in_data,
  output fdl_pkg::out_t out_data
);
  import fdl_pkg::*;

  localparam int AW         = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int CW         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW         = AW + SCALE_BITS;
  localparam int PXW        = PW + 1;
  localparam int SPAN       = DELAY_DEPTH * (2 ** SCALE_BITS);
  localparam int SW         = SAMPLE_BITS;
  localparam int MA_W       = LP_W + 1;
  localparam int MB_W       = COEF_W + 1;
  localparam int PROD_W     = MA_W + MB_W;
  localparam int LP_SHIFT   = 15;
  localparam int DIST_SHIFT = 15;
  localparam int OUT_SHIFT  = 20;
  localparam logic [AW-1:0] LAST = AW'(DELAY_DEPTH - 1);

  function automatic logic signed [PROD_W-1:0] round_shift(
    input logic signed [PROD_W-1:0] v,
    input int                       sh
  );
    logic signed [PROD_W-1:0] half;
    half = '0;
    half[sh-1] = 1'b1;
    return (v + half) >>> sh;
  endfunction

  logic signed [SW-1:0]     mem [CHANNELS][DELAY_DEPTH];
  logic [AW-1:0]            wpos_r [CHANNELS];
  logic                     wrap_r [CHANNELS];
  logic signed [LP_W-1:0]   lp_r [CHANNELS];

  logic [CW-1:0]            ch_r;
  logic signed [SW-1:0]     x_r;
  logic [AW-1:0]            w_r;
  logic [AW-1:0]            i1_r;
  logic [AW-1:0]            i2_r;
  logic [SCALE_BITS-1:0]    frac_r;
  logic                     v1_r;
  logic                     v2_r;
  logic signed [SW-1:0]     rd_r;
  logic signed [SW-1:0]     s1_r;
  logic signed [SW:0]       diff_r;
  logic signed [PROD_W-1:0] p_r;
  logic signed [MA_W-1:0]   e_r;
  logic signed [LP_W-1:0]   lpn_r;
  logic signed [MA_W-1:0]   t_r;
  out_t                     out_r;

  logic [CW-1:0]            ch_in;
  logic [PXW-1:0]           pos_raw;
  logic [PXW-1:0]           pos;
  logic [AW-1:0]            i1;
  logic [AW-1:0]            i2;
  logic signed [SW-1:0]     s2;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [MA_W-1:0]   err;
  logic signed [PROD_W-1:0] lp_sum;
  logic                     lp_fit;
  logic signed [LP_W-1:0]   lp_new;
  logic signed [PROD_W-1:0] y;
  logic                     y_fit;
  logic signed [SW-1:0]     ys;

  assign ch_in = (CHANNELS > 1) ? CW'(in_data.channel) : '0;

  always_comb begin
    pos_raw = PXW'({w_r, {SCALE_BITS{1'b0}}}) + PXW'(SPAN) - PXW'(cfg.delay_amount);
    pos     = (pos_raw >= PXW'(SPAN)) ? pos_raw - PXW'(SPAN) : pos_raw;
    i1      = pos[PW-1:SCALE_BITS];
    i2      = (i1 == LAST) ? '0 : i1 + 1'b1;
  end

  assign s2 = v2_r ? rd_r : '0;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      OP_MUL_INTERP: begin
        mul_a = MA_W'(diff_r);
        mul_b = MB_W'(frac_r);
      end
      OP_MUL_LP: begin
        mul_a = e_r;
        mul_b = MB_W'(cfg.lowpass_coeff);
      end
      OP_MUL_DIST: begin
        mul_a = MA_W'(lpn_r);
        mul_b = MB_W'(cfg.distance_gain);
      end
      OP_MUL_OUT: begin
        mul_a = t_r;
        mul_b = MB_W'(cfg.output_gain);
      end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    err    = (MA_W'(s1_r) <<< SCALE_BITS) + MA_W'(p_r) - MA_W'(lp_r[ch_r]);
    lp_sum = PROD_W'(lp_r[ch_r]) + round_shift(p_r, LP_SHIFT);
    lp_fit = (&lp_sum[PROD_W-1:LP_W-1]) || !(|lp_sum[PROD_W-1:LP_W-1]);
    lp_new = lp_fit ? lp_sum[LP_W-1:0]
                    : {lp_sum[PROD_W-1], {(LP_W-1){~lp_sum[PROD_W-1]}}};
    y      = round_shift(p_r, OUT_SHIFT);
    y_fit  = (&y[PROD_W-1:SW-1]) || !(|y[PROD_W-1:SW-1]);
    ys     = y_fit ? y[SW-1:0] : {y[PROD_W-1], {(SW-1){~y[PROD_W-1]}}};
  end

  // channel state: write positions, fill marks, lowpass state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        wpos_r[c] <= '0;
        wrap_r[c] <= 1'b0;
        lp_r[c]   <= '0;
      end
    end else begin
      case (op)
        OP_LP_UPD: lp_r[ch_r] <= lp_new;
        OP_FINISH: begin
          wpos_r[ch_r] <= (w_r == LAST) ? '0 : w_r + 1'b1;
          if (w_r == LAST) begin
            wrap_r[ch_r] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // delay memory with registered read data
  always_ff @(posedge clk) begin
    if (op == OP_WRITE) begin
      mem[ch_r][w_r] <= x_r;
    end
    if (op == OP_READ1) begin
      rd_r <= mem[ch_r][i1_r];
    end else if (op == OP_READ2) begin
      rd_r <= mem[ch_r][i2_r];
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        ch_r <= ch_in;
        x_r  <= in_data.sample_in;
        w_r  <= wpos_r[ch_in];
      end
      OP_WRITE: begin
        i1_r   <= i1;
        i2_r   <= i2;
        frac_r <= pos[SCALE_BITS-1:0];
        v1_r   <= wrap_r[ch_r] || (i1 <= w_r);
        v2_r   <= wrap_r[ch_r] || (i2 <= w_r);
      end
      OP_READ2:      s1_r   <= v1_r ? rd_r : '0;
      OP_DIFF:       diff_r <= (SW+1)'(s2) - (SW+1)'(s1_r);
      OP_MUL_INTERP: p_r    <= mul_p;
      OP_ERR:        e_r    <= err;
      OP_MUL_LP:     p_r    <= mul_p;
      OP_LP_UPD:     lpn_r  <= lp_new;
      OP_MUL_DIST:   p_r    <= mul_p;
      OP_ROUND_T:    t_r    <= MA_W'(round_shift(p_r, DIST_SHIFT));
      OP_MUL_OUT:    p_r    <= mul_p;
      OP_FINISH: begin
        out_r.sample_out <= ys;
        out_r.clipped    <= !y_fit;
      end
      OP_BYPASS: begin
        out_r.sample_out <= x_r;
        out_r.clipped    <= 1'b0;
      end
      default: ;
    endcase
  end

  assign out_data = out_r;

endmodule

>>> rtl/fdl_ctrl.sv
// Controller: sequences one sample through the datapath, one operation a cycle
// unless output is full, owns in_ready/out_valid handshake. Depends on fdl_pkg.
module fdl_ctrl (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         bypass,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  output fdl_pkg::op_t op
);
  import fdl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRITE,
    S_READ1,
    S_READ2,
    S_DIFF,
    S_MUL_INTERP,
    S_ERR,
    S_MUL_LP,
    S_LP_UPD,
    S_MUL_DIST,
    S_ROUND_T,
    S_MUL_OUT,
    S_FINISH,
    S_BYPASS
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    op            = OP_NONE;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = OP_LOAD;
          state_nxt = bypass ? S_BYPASS : S_WRITE;
        end
      end
      S_WRITE: begin
        op        = OP_WRITE;
        state_nxt = S_READ1;
      end
      S_READ1: begin
        op        = OP_READ1;
        state_nxt = S_READ2;
      end
      S_READ2: begin
        op        = OP_READ2;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        op        = OP_DIFF;
        state_nxt = S_MUL_INTERP;
      end
      S_MUL_INTERP: begin
        op        = OP_MUL_INTERP;
        state_nxt = S_ERR;
      end
      S_ERR: begin
        op        = OP_ERR;
        state_nxt = S_MUL_LP;
      end
      S_MUL_LP: begin
        op        = OP_MUL_LP;
        state_nxt = S_LP_UPD;
      end
      S_LP_UPD: begin
        op        = OP_LP_UPD;
        state_nxt = S_MUL_DIST;
      end
      S_MUL_DIST: begin
        op        = OP_MUL_DIST;
        state_nxt = S_ROUND_T;
      end
      S_ROUND_T: begin
        op        = OP_ROUND_T;
        state_nxt = S_MUL_OUT;
      end
      S_MUL_OUT: begin
        op        = OP_MUL_OUT;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (slot_free) begin
          op            = OP_FINISH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_BYPASS: begin
        if (slot_free) begin
          op            = OP_BYPASS;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> rtl/fractional_delay_lowpass_gain.sv
// Top level: configuration registers, controller and datapath.
// Depends on fdl_pkg, fdl_ctrl and fdl_datapath.
//
// Each accepted beat is written into its channel's circular delay memory, read
// back at a Q8.8 fractional delay with linear interpolation, filtered by the
// channel's one-pole lowpass, scaled by the distance and output gains and
// saturated to 24 bits. Each sample passes through the controller's states in
// order before the next beat is taken: the two delay memory reads come one
// after the other through a single read port, and the interpolation, lowpass,
// distance and output products share one multiplier, the last three each
// followed by its rounding step.
// The next beat is accepted as soon as the controller is back in idle, while
// the previous result may still wait in the output register. No clearing pass
// runs after reset: a per-channel fill mark makes never-written entries read
// as zero. Write configuration only while no sample is in flight.
module fractional_delay_lowpass_gain #(
  parameter int DELAY_DEPTH = fdl_pkg::DELAY_DEPTH_DEF,
  parameter int CHANNELS    = fdl_pkg::CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fdl_pkg::in_t      in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output fdl_pkg::out_t     out_data,
  input  logic              cfg_we,
  input  fdl_pkg::cfg_idx_t cfg_index,
  input  logic [15:0]       cfg_data
);
  import fdl_pkg::*;

  cfg_t cfg_r;
  op_t  op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bypass        <= 1'b0;
      cfg_r.delay_amount  <= DELAY_RST;
      cfg_r.lowpass_coeff <= LP_COEFF_RST;
      cfg_r.distance_gain <= DIST_GAIN_RST;
      cfg_r.output_gain   <= OUT_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BYPASS:    cfg_r.bypass        <= cfg_data[0];
        CFG_DELAY:     cfg_r.delay_amount  <= cfg_data;
        CFG_LP_COEFF:  cfg_r.lowpass_coeff <= cfg_data;
        CFG_DIST_GAIN: cfg_r.distance_gain <= cfg_data;
        CFG_OUT_GAIN:  cfg_r.output_gain   <= cfg_data;
        default: ;
      endcase
    end
  end

  fdl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .bypass    (cfg_r.bypass),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .op        (op)
  );

  fdl_datapath #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .CHANNELS    (CHANNELS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op),
    .cfg      (cfg_r),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule
